>>> hdl/zbcs_pkg.sv
// ----------------------------------------------------------------------------
// zbcs_pkg
// Shared types and constants for the column span fill with depth store.
// ----------------------------------------------------------------------------
package zbcs_pkg;

    localparam int SCREEN_WIDTH_DEF  = 84;
    localparam int SCREEN_HEIGHT_DEF = 48;

    // dividend width: two 25x24 products summed
    localparam int NUM_W = 50;

    localparam logic [1:0] MODE_MARK   = 2'd0;
    localparam logic [1:0] MODE_FILL   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] KIND_WHITE       = 2'd0;
    localparam logic [1:0] KIND_BLACK       = 2'd1;
    localparam logic [1:0] KIND_TRANSPARENT = 2'd2;
    localparam logic [1:0] KIND_UNUSED      = 2'd3;

    localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [6:0]         column;
        logic [5:0]         row;
        logic [1:0]         fill_kind;
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic signed [23:0] vertex_z;
        logic signed [23:0] normal_x;
        logic signed [23:0] normal_y;
        logic signed [23:0] normal_z;
    } in_item_t;

    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic       pixel_on;
        logic       last_of_column;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic edge_rd;
        logic edge_mark;
        logic edge_clear;
        logic prep;
        logic row_start;
        logic sum;
        logic zcalc;
        logic cmp;
        logic y_inc;
        logic flush;
        logic clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       col_ok;
        logic       bits_any;
        logic       nz_zero;
        logic       in_span;
        logic       y_last;
        logic       div_done;
        logic       clr_last;
    } dp_stat_t;

endpackage

>>> hdl/zbcs_div.sv
// ----------------------------------------------------------------------------
// zbcs_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module zbcs_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [zbcs_pkg::NUM_W-1:0] dividend,
    input  logic signed [23:0]             divisor,
    output logic                           done,
    output logic signed [zbcs_pkg::NUM_W:0] quotient
);
    import zbcs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [24:0]       rem_reg;
    logic [23:0]       dmag_reg;
    logic              neg_reg;

    logic [NUM_W-1:0]  num_mag;
    logic [23:0]       den_mag;
    logic [24:0]       rem_sh;
    logic              fits;

    assign num_mag = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
    assign den_mag = divisor[23] ? 24'(-divisor) : 24'(divisor);
    assign rem_sh  = {rem_reg[23:0], quo_reg[NUM_W-1]};
    assign fits    = (rem_sh >= {1'b0, dmag_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= num_mag;
            rem_reg  <= '0;
            dmag_reg <= den_mag;
            neg_reg  <= dividend[NUM_W-1] ^ divisor[23];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

>>> hdl/zbcs_datapath.sv
// ----------------------------------------------------------------------------
// zbcs_datapath
// Edge bitmap, depth store, plane depth arithmetic and result staging.
// ----------------------------------------------------------------------------
module zbcs_datapath #(
    parameter int SCREEN_WIDTH  = zbcs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = zbcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  zbcs_pkg::in_item_t  item,
    input  zbcs_pkg::dp_cmd_t   cmd,
    output zbcs_pkg::dp_stat_t  stat,
    output logic                result_valid,
    output zbcs_pkg::out_item_t result
);
    import zbcs_pkg::*;

    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [51:0] Z_MAX = 52'sd2147483647;
    localparam logic signed [51:0] Z_MIN = -52'sd2147483648;

    in_item_t                  item_reg;

    logic [SCREEN_HEIGHT-1:0]  edge_mem [SCREEN_WIDTH];
    logic [SCREEN_WIDTH-1:0]   edge_vld_reg;
    logic [SCREEN_HEIGHT-1:0]  edge_rd_reg;
    logic                      edge_hit_reg;
    logic [SCREEN_HEIGHT-1:0]  span_bits_reg;

    logic signed [31:0]        depth_mem [DEPTH];
    logic signed [31:0]        depth_rd_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [AW-1:0]             base_reg;
    logic [YW-1:0]             y_reg;

    logic signed [48:0]        p1_reg;
    logic signed [48:0]        p2_reg;
    logic signed [31:0]        z_reg;

    out_item_t                 pend_reg;
    logic                      pend_vld_reg;
    out_item_t                 result_reg;
    logic                      result_valid_reg;

    logic                      col_ok;
    logic                      row_ok;
    logic [CW-1:0]             col_idx;
    logic [YW-1:0]             row_idx;
    logic [SCREEN_HEIGHT-1:0]  bits;
    logic                      edge_we;
    logic [SCREEN_HEIGHT-1:0]  edge_wdata;
    logic signed [24:0]        dx;
    logic signed [24:0]        dy;
    logic [16:0]               yext;
    logic signed [48:0]        prod1;
    logic signed [48:0]        prod2;
    logic                      div_done;
    logic signed [NUM_W:0]     quo;
    logic signed [51:0]        z_wide;
    logic [AW-1:0]             pix_addr;
    logic                      win;
    logic                      kind_solid;
    logic                      edge_bit;
    logic                      emit;
    out_item_t                 new_pix;
    out_item_t                 last_pix;
    logic [SCREEN_HEIGHT-1:0]  hi_m;
    logic [SCREEN_HEIGHT-1:0]  lo_m;
    logic                      depth_we;
    logic [AW-1:0]             depth_waddr;
    logic signed [31:0]        depth_wdata;

    assign col_ok  = (int'(item_reg.column) < SCREEN_WIDTH);
    assign row_ok  = (int'(item_reg.row) < SCREEN_HEIGHT);
    assign col_idx = col_ok ? CW'(item_reg.column) : '0;
    assign row_idx = row_ok ? YW'(item_reg.row) : '0;
    assign bits    = edge_hit_reg ? edge_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
    end

    // edge bitmap: one column per entry, valid bit stands for the reset zero
    assign edge_we    = col_ok && ((cmd.edge_mark && row_ok) || cmd.edge_clear);
    assign edge_wdata = cmd.edge_mark ? (bits | (SCREEN_HEIGHT'(1) << row_idx)) : '0;

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[col_idx] <= edge_wdata;
        end
        if (cmd.edge_rd)
        begin
            edge_rd_reg <= edge_mem[col_idx];
        end
        if (cmd.edge_clear)
        begin
            span_bits_reg <= bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_vld_reg <= '0;
            edge_hit_reg <= 1'b0;
        end
        else
        begin
            if (edge_we)
            begin
                edge_vld_reg[col_idx] <= 1'b1;
            end
            if (cmd.edge_rd)
            begin
                edge_hit_reg <= edge_vld_reg[col_idx];
            end
        end
    end

    // span test: some edge bit at or above y and some at or below y
    always_comb
    begin
        for (int i = 0; i < SCREEN_HEIGHT; i++)
        begin
            hi_m[i] = (i >= int'(y_reg));
            lo_m[i] = (i <= int'(y_reg));
        end
    end

    // plane depth arithmetic
    assign yext  = 17'(y_reg);
    assign dx    = signed'({10'b0, item_reg.column, 8'b0}) - 25'(item_reg.vertex_x);
    assign dy    = signed'({yext, 8'b0}) - 25'(item_reg.vertex_y);
    assign prod1 = dx * item_reg.normal_x;
    assign prod2 = dy * item_reg.normal_y;

    zbcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sum),
        .dividend (NUM_W'(p1_reg) + NUM_W'(p2_reg)),
        .divisor  (item_reg.normal_z),
        .done     (div_done),
        .quotient (quo)
    );

    assign z_wide = 52'(item_reg.vertex_z) - 52'(quo);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            p1_reg   <= prod1;
            base_reg <= AW'(col_idx * SCREEN_HEIGHT);
        end
        if (cmd.row_start)
        begin
            p2_reg <= prod2;
        end
        if (cmd.zcalc)
        begin
            if (z_wide > Z_MAX)
            begin
                z_reg <= Z_MAX[31:0];
            end
            else if (z_wide < Z_MIN)
            begin
                z_reg <= Z_MIN[31:0];
            end
            else
            begin
                z_reg <= z_wide[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_reg <= '0;
        end
        else if (cmd.edge_clear)
        begin
            y_reg <= '0;
        end
        else if (cmd.y_inc)
        begin
            y_reg <= y_reg + 1'b1;
        end
    end

    // depth store: clearing sweep or per-pixel write
    assign pix_addr   = base_reg + AW'(y_reg);
    assign win        = (depth_rd_reg < z_reg);
    assign kind_solid = (item_reg.fill_kind == KIND_WHITE) ||
                        (item_reg.fill_kind == KIND_BLACK);
    assign edge_bit   = span_bits_reg[y_reg];
    assign emit       = cmd.cmp && win && (kind_solid || edge_bit);

    assign depth_we    = cmd.clr_step || (cmd.cmp && win && kind_solid);
    assign depth_waddr = cmd.clr_step ? clr_addr_reg : pix_addr;
    assign depth_wdata = cmd.clr_step ? DEPTH_MIN : z_reg;

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[depth_waddr] <= depth_wdata;
        end
        if (cmd.row_start)
        begin
            depth_rd_reg <= depth_mem[pix_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= stat.clr_last ? '0 : clr_addr_reg + 1'b1;
        end
    end

    // hold one pixel back so the final one can be flagged
    always_comb
    begin
        new_pix.pixel_x        = item_reg.column;
        new_pix.pixel_y        = 6'(y_reg);
        new_pix.pixel_on       = (item_reg.fill_kind == KIND_WHITE) ? edge_bit :
                                 (item_reg.fill_kind == KIND_BLACK) ? ~edge_bit : 1'b1;
        new_pix.last_of_column = 1'b0;
        last_pix                = pend_reg;
        last_pix.last_of_column = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (emit)
            begin
                pend_vld_reg     <= 1'b1;
                result_valid_reg <= pend_vld_reg;
            end
            else if (cmd.flush)
            begin
                pend_vld_reg     <= 1'b0;
                result_valid_reg <= pend_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pend_reg   <= new_pix;
            result_reg <= pend_reg;
        end
        else if (cmd.flush)
        begin
            result_reg <= last_pix;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        stat.mode     = item_reg.mode;
        stat.col_ok   = col_ok;
        stat.bits_any = |bits;
        stat.nz_zero  = (item_reg.normal_z == 24'sd0);
        stat.in_span  = (|(span_bits_reg & hi_m)) && (|(span_bits_reg & lo_m));
        stat.y_last   = (y_reg == YW'(SCREEN_HEIGHT - 1));
        stat.div_done = div_done;
        stat.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    end

endmodule

>>> hdl/zbcs_ctrl.sv
// ----------------------------------------------------------------------------
// zbcs_ctrl
// Sequencer for marking, column fill and depth store clearing.
// ----------------------------------------------------------------------------
module zbcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  zbcs_pkg::dp_stat_t stat,
    output zbcs_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import zbcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_ERD,
        S_EDEC,
        S_PREP,
        S_ROW,
        S_SUM,
        S_DIV,
        S_ZC,
        S_CMP,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch = start;
                if (start)
                begin
                    state_next = S_ERD;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = S_EDEC;
            end
            S_EDEC:
            begin
                state_next = S_IDLE;
                priority if (stat.mode == MODE_MARK)
                begin
                    cmd.edge_mark = 1'b1;
                end
                else if (stat.mode == MODE_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.mode == MODE_FILL && stat.col_ok && stat.bits_any)
                begin
                    cmd.edge_clear = 1'b1;
                    if (!stat.nz_zero)
                    begin
                        state_next = S_PREP;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                if (stat.in_span)
                begin
                    cmd.row_start = 1'b1;
                    state_next    = S_SUM;
                end
                else if (stat.y_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.y_inc = 1'b1;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_ZC;
                end
            end
            S_ZC:
            begin
                cmd.zcalc  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (stat.y_last)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.y_inc  = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reset starts with a sweep of the depth store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> hdl/zbuffer_column_span_fill.sv
// ----------------------------------------------------------------------------
// zbuffer_column_span_fill
// Column span fill with per-pixel depth test for a small one-bit display.
// ----------------------------------------------------------------------------
// Mark edge, or fill of an empty or skipped column: edge read and decode, then idle.
// Column fill: prep, then a span test per row; each span pixel runs row start, sum, divide, depth
//   calc and compare on the one-bit-per-cycle divider; results trail by one pixel.
// Depth store clear: edge read and decode, then a sweep of all SCREEN_WIDTH*SCREEN_HEIGHT entries, one entry a cycle.
// After reset the same clearing sweep runs with busy high.
// Results appear for one cycle on result_valid; the receiver cannot stall.
module zbuffer_column_span_fill #(
    parameter int SCREEN_WIDTH  = zbcs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = zbcs_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  zbcs_pkg::in_item_t  item,
    output logic                result_valid,
    output zbcs_pkg::out_item_t result
);
    import zbcs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    zbcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    zbcs_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without an item in progress");

    a_result_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((int'(result.pixel_x) < SCREEN_WIDTH) &&
                          (int'(result.pixel_y) < SCREEN_HEIGHT)))
        else $error("result pixel off screen");

endmodule
